// ===== hw/rtl/mpq_pkg.sv =====
// Package for the min-first priority queue: payload types and status codes.
`default_nettype none
package mpq_pkg;

    // Request types
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } mpq_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic               is_empty;
        logic [4:0]         fill_count;
    } mpq_rsp_t;

    // One stored entry
    typedef struct packed {
        logic signed [31:0] value;
        logic signed [15:0] prio;
    } mpq_entry_t;

    // Operation broadcast to every cell in a cycle
    typedef struct packed {
        logic       enq;
        logic       deq;
        mpq_entry_t entry;
    } mpq_op_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mpq_req_if.sv =====
// Request channel interface: valid/ready with one request word.
`default_nettype none
interface mpq_req_if
    import mpq_pkg::*;
();
    logic     valid;
    logic     ready;
    mpq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mpq_rsp_if.sv =====
// Result channel interface: valid/ready with one result word.
`default_nettype none
interface mpq_rsp_if
    import mpq_pkg::*;
();
    logic     valid;
    logic     ready;
    mpq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/min_priority_queue.sv =====
// Min-first priority queue: top level over a chain of sorted cells.
// The result word is registered when the request is taken.
// Throughput: one request per cycle unless a result word is stalled; every cell
// compares its entry with the broadcast priority and may shift with a neighbor in that same cycle.
// Reset: cell valid bits, the entry count and the result valid are cleared;
// entry payloads are left as they are.
`default_nettype none
module min_priority_queue
    import mpq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpq_req_if.sink   req,
    mpq_rsp_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          rsp_valid_reg;
    mpq_rsp_t      rsp_data_reg;
    mpq_rsp_t      rsp_data_next;

    logic          fire;
    logic          full;
    logic          empty;
    mpq_op_t       op;

    logic       cell_valid [CAPACITY];
    mpq_entry_t cell_entry [CAPACITY];
    logic       cell_le    [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);

    // Broadcast operation, gated by fill state
    always_comb
    begin
        op.enq              = fire && (req.data.req_type == REQ_ENQ) && !full;
        op.deq              = fire && (req.data.req_type == REQ_DEQ) && !empty;
        op.entry.value      = req.data.item_value;
        op.entry.prio       = req.data.item_priority;
    end

    // Cell chain, head at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic       p_le;
        logic       p_valid;
        mpq_entry_t p_entry;
        logic       n_valid;
        mpq_entry_t n_entry;

        if (i == 0)
        begin : g_head
            assign p_le    = 1'b1;
            assign p_valid = 1'b0;
            assign p_entry = '0;
        end
        else
        begin : g_mid
            assign p_le    = cell_le[i-1];
            assign p_valid = cell_valid[i-1];
            assign p_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign n_valid = 1'b0;
            assign n_entry = '0;
        end
        else
        begin : g_body
            assign n_valid = cell_valid[i+1];
            assign n_entry = cell_entry[i+1];
        end

        mpq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .prev_le    (p_le),
            .prev_valid (p_valid),
            .prev_entry (p_entry),
            .next_valid (n_valid),
            .next_entry (n_entry),
            .valid      (cell_valid[i]),
            .entry      (cell_entry[i]),
            .le         (cell_le[i])
        );
    end

    // Count and result word
    always_comb
    begin
        count_next               = count_reg;
        rsp_data_next.status     = ST_DONE;
        rsp_data_next.out_value  = '0;
        if (req.data.req_type == REQ_ENQ)
        begin
            if (full)
            begin
                rsp_data_next.status = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                rsp_data_next.status    = ST_EMPTY;
                rsp_data_next.out_value = EMPTY_VALUE;
            end
            else
            begin
                count_next              = count_reg - CW'(1);
                rsp_data_next.out_value = cell_entry[0].value;
            end
        end
        rsp_data_next.is_empty   = (count_next == '0);
        rsp_data_next.fill_count = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/mpq_cell.sv =====
// One cell of the sorted chain: holds one entry, shifts with its neighbors.
`default_nettype none
module mpq_cell
    import mpq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire mpq_op_t    op,
    input  wire logic       prev_le,
    input  wire logic       prev_valid,
    input  wire mpq_entry_t prev_entry,
    input  wire logic       next_valid,
    input  wire mpq_entry_t next_entry,
    output logic            valid,
    output mpq_entry_t      entry,
    output logic            le
);

    logic       valid_reg;
    logic       valid_next;
    mpq_entry_t entry_reg;
    mpq_entry_t entry_next;

    // Entry stays ahead of the new one when its priority is not greater
    assign le = valid_reg && (entry_reg.prio <= op.entry.prio);

    // Enqueue: keep, take the new entry, or take the one from the left.
    // Dequeue: everything moves one place toward the head.
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (op.enq)
        begin
            if (!le)
            begin
                if (prev_le)
                begin
                    valid_next = 1'b1;
                    entry_next = op.entry;
                end
                else
                begin
                    valid_next = prev_valid;
                    entry_next = prev_entry;
                end
            end
        end
        else if (op.deq)
        begin
            valid_next = next_valid;
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule
`default_nettype wire

// ===== tb/min_priority_queue_test.sv =====
// Testbench for min_priority_queue: random and directed requests checked by a scoreboard.
`timescale 1ns / 1ps

// Tracks the queue contents and holds the result words still to come.
class queue_scoreboard;
    localparam int DEPTH = 16;

    logic signed [31:0] held_value [DEPTH];
    logic signed [15:0] held_prio [DEPTH];
    int unsigned        held_count;
    mpq_pkg::mpq_rsp_t  due_results [$];
    int unsigned        faults;

    function new();
        held_count = 0;
        faults     = 0;
    endfunction

    // Apply one accepted request and queue the result word it must produce.
    function void note_request(mpq_pkg::mpq_req_t w);
        mpq_pkg::mpq_rsp_t r;
        int unsigned       slot;
        int unsigned       k;
        r.status    = mpq_pkg::ST_DONE;
        r.out_value = '0;
        if (w.req_type == mpq_pkg::REQ_ENQ)
        begin
            if (held_count >= DEPTH)
                r.status = mpq_pkg::ST_FULL;
            else
            begin
                // Sorted insert; ties go behind older entries
                slot = held_count;
                while (slot > 0 && held_prio[slot - 1] > w.item_priority)
                begin
                    held_value[slot] = held_value[slot - 1];
                    held_prio[slot]  = held_prio[slot - 1];
                    slot--;
                end
                held_value[slot] = w.item_value;
                held_prio[slot]  = w.item_priority;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                r.status    = mpq_pkg::ST_EMPTY;
                r.out_value = mpq_pkg::EMPTY_VALUE;
            end
            else
            begin
                // Take the head and close the gap
                r.out_value = held_value[0];
                for (k = 1; k < held_count; k++)
                begin
                    held_value[k - 1] = held_value[k];
                    held_prio[k - 1]  = held_prio[k];
                end
                held_count--;
            end
        end
        r.is_empty   = (held_count == 0);
        r.fill_count = 5'(held_count);
        due_results.push_back(r);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] seen);
        $display("%0t: wrong %s, expected %h, got %h", $time, field, want, seen);
        faults++;
    endfunction

    // Compare one accepted result word with the oldest one due.
    function void check_result(mpq_pkg::mpq_rsp_t got);
        mpq_pkg::mpq_rsp_t want;
        if (due_results.size() == 0)
        begin
            $display("%0t: unexpected result word, expected none, got %h", $time, got);
            faults++;
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status)
            report_field("status", 32'(want.status), 32'(got.status));
        if (got.out_value !== want.out_value)
            report_field("out_value", want.out_value, got.out_value);
        if (got.is_empty !== want.is_empty)
            report_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
        if (got.fill_count !== want.fill_count)
            report_field("fill_count", 32'(want.fill_count), 32'(got.fill_count));
    endfunction
endclass

module min_priority_queue_test;
    import mpq_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 375;
    localparam int DRAIN_CYCLES = 10;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mpq_req_if req_ch ();
    mpq_rsp_if rsp_ch ();

    min_priority_queue #(
        .CAPACITY (16)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    queue_scoreboard board = new();

    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;
    int unsigned rsp_words  = 0;
    int unsigned quiet      = 0;

    always #5 clk = ~clk;

    // Random request word; dequeue words still carry random payload bits
    function automatic mpq_req_t random_word(int unsigned enq_pct);
        mpq_req_t w;
        w.req_type = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        case ($urandom_range(7))
            0: w.item_value = 32'h8000_0000;
            1: w.item_value = 32'h7FFF_FFFF;
            2: w.item_value = 32'hFFFF_FFFF;
            default: w.item_value = $urandom;
        endcase
        case ($urandom_range(3))
            0: w.item_priority = 16'($urandom);
            1: w.item_priority = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: w.item_priority = $signed(16'($urandom_range(6))) - 16'sd3;
        endcase
        return w;
    endfunction

    // Offer one word after a random gap; returns at the falling edge after acceptance
    task automatic send_word(input mpq_req_t w);
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= random_word(50);
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(w);
        @(negedge clk);
    endtask

    task automatic push_entry(input logic [31:0] value, input logic [15:0] prio);
        mpq_req_t w;
        w.req_type      = REQ_ENQ;
        w.item_value    = value;
        w.item_priority = prio;
        send_word(w);
    endtask

    task automatic pop_entry();
        mpq_req_t w;
        w          = random_word(0);
        w.req_type = REQ_DEQ;
        send_word(w);
    endtask

    // Result receiver: random stalls plus one long hold-off to fill the block
    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (rsp_words >= HOLD_AT && !hold_done)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            board.check_result(rsp_ch.data);
            rsp_words <= rsp_words + 1;
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("min_priority_queue: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int unsigned phase;
        int unsigned sent;
        int unsigned burst;
        int unsigned enq_pct;
        int unsigned k;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty dequeue, extremes, ties, full drop, head replacement
        pop_entry();
        push_entry(32'h7FFF_FFFF, 16'sh7FFF);
        push_entry(32'h8000_0000, 16'sh8000);
        push_entry(32'hFFFF_FFFF, 16'sh0000);
        push_entry(32'h0000_0000, 16'sh0000);
        for (k = 0; k < 12; k++)
            push_entry(32'h0000_1000 + k, 16'(3 - int'(k / 3)));
        push_entry(32'h0000_007B, 16'sh8000);
        pop_entry();
        push_entry(32'h55AA_55AA, 16'sh8000);
        pop_entry();
        pop_entry();
        pop_entry();

        // Random phases: none, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle <= 0;  recv_stall <= 0;  end
                1: begin send_idle <= 75; recv_stall <= 0;  end
                2: begin send_idle <= 0;  recv_stall <= 75; end
                default: begin send_idle <= 31; recv_stall <= 31; end
            endcase
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                // Bursts biased toward filling, draining or churning
                burst = $urandom_range(10, 40);
                case ($urandom_range(2))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    default: enq_pct = 85;
                endcase
                for (k = 0; k < burst; k++)
                    send_word(random_word(enq_pct));
                sent += burst;
            end
        end

        // Drain
        req_ch.valid <= 1'b0;
        send_idle    <= 0;
        recv_stall   <= 0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.faults == 0 && board.due_results.size() == 0)
            $display("min_priority_queue: match");
        else
            $display("min_priority_queue: mismatch");
        $finish;
    end
endmodule
